>>> design/sin_cos_tan_taylor_degrees_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Taylor series sine, cosine and tangent block.
// ----------------------------------------------------------------------------
`ifndef SIN_COS_TAN_TAYLOR_DEGREES_ASSERT_SVH
`define SIN_COS_TAN_TAYLOR_DEGREES_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types and constants of the Taylor series block.
// ----------------------------------------------------------------------------
`default_nettype none

package tsd_pkg;

    localparam int MAX_TERMS_DEF        = 15;
    localparam int ANGLE_FRAC_BITS_DEF  = 22;
    localparam int RESULT_FRAC_BITS_DEF = 30;

    localparam int ANGLE_W  = 32;
    localparam int VALUE_W  = 48;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] SAT_MAG = 64'h4000_0000_0000_0000;
    localparam logic [63:0] TAN_CAP = 64'h0004_0000_0000_0000;

    localparam logic [1:0] ACT_SIN = 2'd0;
    localparam logic [1:0] ACT_COS = 2'd1;
    localparam logic [1:0] ACT_TAN = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NEAR = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SERIES_TERMS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_ZERO    = 1'b1;

    typedef struct packed {
        logic [1:0]                action;
        logic signed [ANGLE_W-1:0] angle_degrees;
    } t_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                status;
    } t_result;

endpackage

`default_nettype wire

>>> design/tsd_mul.sv
// ----------------------------------------------------------------------------
// tsd_mul
// Shared 64 by 64 multiplier built from one 32 by 32 multiplier that forms
// four partial products in turn, followed by rounding, a fixed right shift and
// saturation, or, in reciprocal mode, by a plain right shift of 63 plus i_rsh
// that turns a multiply by a scaled reciprocal into a division.
// ----------------------------------------------------------------------------
`default_nettype none

module tsd_mul #(
    parameter int ANGLE_FRAC_BITS  = tsd_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int RESULT_FRAC_BITS = tsd_pkg::RESULT_FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic        i_rad,
    input  wire logic        i_recip,
    input  wire logic [3:0]  i_rsh,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic [63:0]      o_res
);
    import tsd_pkg::*;

    localparam int SH_RAD = ANGLE_FRAC_BITS + 60 - RESULT_FRAC_BITS;
    localparam int SH_RES = RESULT_FRAC_BITS;

    logic          r_busy;
    logic [2:0]    r_cnt;
    logic [63:0]   r_a;
    logic [63:0]   r_b;
    logic          r_rad;
    logic          r_recip;
    logic [3:0]    r_rsh;
    logic [63:0]   r_prod;
    logic [1:0]    r_pcode;
    logic [127:0]  r_acc;
    logic          r_done;
    logic [63:0]   r_res;

    logic [31:0]   a_part;
    logic [31:0]   b_part;
    logic [127:0]  prod_sh;
    logic [127:0]  t_rad;
    logic [127:0]  t_res;
    logic [127:0]  q_sel;
    logic [63:0]   rnd_res;
    logic [63:0]   q_rcp;

    assign a_part = r_cnt[0] ? r_a[63:32] : r_a[31:0];
    assign b_part = r_cnt[1] ? r_b[63:32] : r_b[31:0];

    always_comb begin
        case (r_pcode)
            2'd0:    prod_sh = {64'd0, r_prod};
            2'd1:    prod_sh = {32'd0, r_prod, 32'd0};
            2'd2:    prod_sh = {r_prod, 64'd0};
            default: prod_sh = 128'd0;
        endcase
    end

    assign t_rad = r_acc + (128'd1 << (SH_RAD - 1));
    assign t_res = r_acc + (128'd1 << (SH_RES - 1));
    assign q_sel = r_rad ? (t_rad >> SH_RAD) : (t_res >> SH_RES);
    assign rnd_res = (q_sel > {64'd0, SAT_MAG}) ? SAT_MAG : q_sel[63:0];
    assign q_rcp = 64'(r_acc[127:63] >> r_rsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_a     <= i_a;
            r_b     <= i_b;
            r_rad   <= i_rad;
            r_recip <= i_recip;
            r_rsh   <= i_rsh;
            r_acc   <= 128'd0;
        end else if (r_busy) begin
            if (r_cnt < 3'd4) begin
                r_prod  <= 64'(a_part) * 64'(b_part);
                r_pcode <= 2'(r_cnt[0]) + 2'(r_cnt[1]);
            end
            if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                r_acc <= r_acc + prod_sh;
            end
            if (r_cnt == 3'd5) begin
                r_res <= r_recip ? q_rcp : rnd_res;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

>>> design/tsd_div.sv
// ----------------------------------------------------------------------------
// tsd_div
// Shared restoring divider, one quotient bit per cycle, for 128-bit
// dividends, with the quotient held at the tangent cap.
// ----------------------------------------------------------------------------
`default_nettype none

module tsd_div (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_go,
    input  wire logic [127:0] i_num,
    input  wire logic [63:0]  i_den,
    output logic              o_done,
    output logic [63:0]       o_quo,
    output logic [63:0]       o_rem
);
    import tsd_pkg::*;

    logic          r_busy;
    logic [7:0]    r_cnt;
    logic [127:0]  r_num;
    logic [63:0]   r_den;
    logic [63:0]   r_rem;
    logic [63:0]   r_quo;
    logic          r_done;

    logic [64:0]   rr;
    logic          ge;
    logic [64:0]   diff;
    logic [63:0]   nq;

    assign rr   = {r_rem, r_num[127]};
    assign ge   = rr >= {1'b0, r_den};
    assign diff = rr - {1'b0, r_den};

    always_comb begin
        nq = {r_quo[62:0], ge};
        if (nq > TAN_CAP) begin
            nq = TAN_CAP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 8'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= 8'd128;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 8'd1;
                if (r_cnt == 8'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= 64'd0;
            r_quo <= 64'd0;
        end else if (r_busy) begin
            r_num <= {r_num[126:0], 1'b0};
            r_rem <= ge ? diff[63:0] : rr[63:0];
            r_quo <= nq;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

>>> design/sin_cos_tan_taylor_degrees.sv
// ----------------------------------------------------------------------------
// sin_cos_tan_taylor_degrees
// Sine, cosine or tangent of an angle in degrees by a Taylor series.
// ----------------------------------------------------------------------------
// An item is taken at a clock edge where start is high and busy is low. It
// carries an action (sine, cosine or tangent) and a signed Q10.22 angle in
// degrees. One result item appears on o_result with o_done high for exactly
// one cycle; the receiver cannot stall it. busy is high from the accepting
// edge until the cycle that shows the result, when a new item may already
// be taken.
// The work runs on one shared multiplier and one shared serial divider that
// yields one quotient bit per cycle. Divisions by constants use the
// multiplier with a scaled reciprocal. Sine and cosine each run one series,
// tangent runs both, and its 128-step division follows both series. A
// tangent with the cosine near zero ends after the cosine series, an unused
// action after the square of the angle. One item is in flight at a time, so
// the block takes no new item until the result of the last one shows.
// Configuration is to be written through i_cfg_we, i_cfg_idx and i_cfg_data
// only while the block is idle; the block itself does not enforce this.
// Reset sets series_terms to 10 and near_zero_limit to 0 and returns the
// sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sin_cos_tan_taylor_degrees_assert.svh"

module sin_cos_tan_taylor_degrees #(
    parameter int MAX_TERMS        = tsd_pkg::MAX_TERMS_DEF,
    parameter int ANGLE_FRAC_BITS  = tsd_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int RESULT_FRAC_BITS = tsd_pkg::RESULT_FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire tsd_pkg::t_item                  i_item,
    output logic                                 o_done,
    output tsd_pkg::t_result                     o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [tsd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [tsd_pkg::CFG_W-1:0]       i_cfg_data
);
    import tsd_pkg::*;

    localparam int IW = $clog2(MAX_TERMS + 1);
    localparam int TW = IW + 1;
    localparam int TAB_N = 2 * (MAX_TERMS + 1);
    localparam logic signed [63:0] DEG_LIM = 64'sd360 <<< ANGLE_FRAC_BITS;
    localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (VALUE_W - 1)) - 64'sd1;
    localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< (VALUE_W - 1));
    localparam logic [63:0] ONE_Q = 64'd1 << RESULT_FRAC_BITS;
    localparam int L180 = $clog2(180);
    localparam logic [63:0] RECIP_180 = 64'(((128'd1 << (63 + L180)) / 128'd180) + 128'd1);
    localparam logic [3:0] RSH_180 = 4'(L180);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RAD_MUL  = 4'd1;
    localparam logic [3:0] S_RAD_DIV  = 4'd2;
    localparam logic [3:0] S_X2_MUL   = 4'd3;
    localparam logic [3:0] S_SER_ADD  = 4'd4;
    localparam logic [3:0] S_TERM_MUL = 4'd5;
    localparam logic [3:0] S_TERM_DIV = 4'd6;
    localparam logic [3:0] S_SER_END  = 4'd7;
    localparam logic [3:0] S_TAN_DIV  = 4'd8;

    logic [3:0]         r_state;
    logic [3:0]         r_series_terms;
    logic [CFG_W-1:0]   r_near_zero_limit;
    logic [1:0]         r_action;
    logic               r_deg_neg;
    logic [63:0]        r_x_mag;
    logic               r_x_neg;
    logic [63:0]        r_x2;
    logic               r_odd;
    logic [IW-1:0]      r_i;
    logic [IW-1:0]      r_n;
    logic [63:0]        r_term_mag;
    logic               r_term_neg;
    logic signed [63:0] r_sum;
    logic [63:0]        r_c_mag;
    logic               r_tan_neg;
    logic               r_done;
    t_result            r_result;

    logic               r_mul_go;
    logic               r_mul_rad;
    logic               r_mul_recip;
    logic [3:0]         r_mul_rsh;
    logic [63:0]        r_mul_a;
    logic [63:0]        r_mul_b;
    logic               r_div_go;
    logic [127:0]       r_div_num;
    logic [63:0]        r_div_den;

    logic               mul_done;
    logic [63:0]        mul_res;
    logic               div_done;
    logic [63:0]        div_quo;
    logic [63:0]        div_rem;

    logic signed [63:0] deg_ext;
    logic signed [63:0] deg_clamped;
    logic [63:0]        deg_mag;
    logic [IW-1:0]      n_lim;
    logic signed [63:0] term_val;
    logic signed [63:0] add_raw;
    logic signed [63:0] add_sat;
    logic [63:0]        sum_mag;
    logic               near_zero;
    logic [TW-1:0]      tab_idx;
    logic [63:0]        tan_q;
    logic signed [63:0] tan_val;

    wire logic [63:0]   recip_tab [TAB_N];
    wire logic [63:0]   half_tab [TAB_N];
    wire logic [3:0]    rsh_tab [TAB_N];

    // Entry j holds the step divisor (j + 1) * (j + 2) as a scaled reciprocal,
    // its half for rounding and the extra shift of the reciprocal product.
    for (genvar j = 0; j < TAB_N; j++) begin : g_recip
        localparam int D = (j + 1) * (j + 2);
        localparam int L = $clog2(D);
        assign recip_tab[j] = 64'(((128'd1 << (63 + L)) / 128'(D)) + 128'd1);
        assign half_tab[j]  = 64'(D / 2);
        assign rsh_tab[j]   = 4'(L);
    end

    function automatic t_result clamp_out(input logic signed [63:0] v);
        t_result res;
        res.status = ST_OK;
        if (v > OUT_MAX) begin
            res.value  = VALUE_W'(OUT_MAX);
            res.status = ST_SAT;
        end else if (v < OUT_MIN) begin
            res.value  = VALUE_W'(OUT_MIN);
            res.status = ST_SAT;
        end else begin
            res.value = VALUE_W'(v);
        end
        return res;
    endfunction

    assign deg_ext = 64'(i_item.angle_degrees);
    assign deg_clamped = (deg_ext > DEG_LIM) ? DEG_LIM :
                         (deg_ext < -DEG_LIM) ? -DEG_LIM : deg_ext;
    assign deg_mag = deg_clamped[63] ? 64'(-deg_clamped) : 64'(deg_clamped);
    assign n_lim = (32'(r_series_terms) > MAX_TERMS) ? IW'(MAX_TERMS)
                                                     : IW'(r_series_terms);

    assign term_val = (r_term_neg ^ r_i[0]) ? -signed'(r_term_mag) : signed'(r_term_mag);
    assign add_raw  = r_sum + term_val;
    assign add_sat  = (add_raw > signed'(SAT_MAG)) ? signed'(SAT_MAG) :
                      (add_raw < -signed'(SAT_MAG)) ? -signed'(SAT_MAG) : add_raw;
    assign sum_mag  = r_sum[63] ? 64'(-r_sum) : 64'(r_sum);
    assign near_zero = sum_mag <= 64'(r_near_zero_limit);
    assign tab_idx = {r_i, r_odd};

    always_comb begin
        tan_q = div_quo;
        if (div_rem >= r_c_mag - div_rem) begin
            tan_q = div_quo + 64'd1;
        end
        if (tan_q > TAN_CAP) begin
            tan_q = TAN_CAP;
        end
        tan_val = r_tan_neg ? -signed'(tan_q) : signed'(tan_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_series_terms    <= 4'd10;
            r_near_zero_limit <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SERIES_TERMS: r_series_terms    <= i_cfg_data[3:0];
                REG_NEAR_ZERO:    r_near_zero_limit <= i_cfg_data;
                default:          r_series_terms    <= r_series_terms;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_done   <= 1'b0;
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_action    <= i_item.action;
                        r_deg_neg   <= deg_clamped[63];
                        r_mul_a     <= deg_mag;
                        r_mul_b     <= PI_Q60;
                        r_mul_rad   <= 1'b1;
                        r_mul_recip <= 1'b0;
                        r_mul_go    <= 1'b1;
                        r_n         <= n_lim;
                        r_state     <= S_RAD_MUL;
                    end
                end
                S_RAD_MUL: begin
                    if (mul_done) begin
                        r_mul_a     <= mul_res + 64'd90;
                        r_mul_b     <= RECIP_180;
                        r_mul_rsh   <= RSH_180;
                        r_mul_recip <= 1'b1;
                        r_mul_go    <= 1'b1;
                        r_state     <= S_RAD_DIV;
                    end
                end
                S_RAD_DIV: begin
                    if (mul_done) begin
                        r_x_mag     <= mul_res;
                        r_x_neg     <= r_deg_neg;
                        r_mul_a     <= mul_res;
                        r_mul_b     <= mul_res;
                        r_mul_rad   <= 1'b0;
                        r_mul_recip <= 1'b0;
                        r_mul_go    <= 1'b1;
                        r_state     <= S_X2_MUL;
                    end
                end
                S_X2_MUL: begin
                    if (mul_done) begin
                        r_x2 <= mul_res;
                        r_i  <= '0;
                        r_sum <= '0;
                        if (r_action == ACT_SIN) begin
                            r_odd      <= 1'b1;
                            r_term_mag <= r_x_mag;
                            r_term_neg <= r_x_neg;
                            r_state    <= S_SER_ADD;
                        end else if (r_action == ACT_COS || r_action == ACT_TAN) begin
                            r_odd      <= 1'b0;
                            r_term_mag <= ONE_Q;
                            r_term_neg <= 1'b0;
                            r_state    <= S_SER_ADD;
                        end else begin
                            r_result.value  <= '0;
                            r_result.status <= ST_OK;
                            r_done          <= 1'b1;
                            r_state         <= S_IDLE;
                        end
                    end
                end
                S_SER_ADD: begin
                    r_sum <= add_sat;
                    if (r_i == r_n) begin
                        r_state <= S_SER_END;
                    end else begin
                        r_mul_a     <= r_term_mag;
                        r_mul_b     <= r_x2;
                        r_mul_rad   <= 1'b0;
                        r_mul_recip <= 1'b0;
                        r_mul_go    <= 1'b1;
                        r_state     <= S_TERM_MUL;
                    end
                end
                S_TERM_MUL: begin
                    if (mul_done) begin
                        r_mul_a     <= mul_res + half_tab[tab_idx];
                        r_mul_b     <= recip_tab[tab_idx];
                        r_mul_rsh   <= rsh_tab[tab_idx];
                        r_mul_recip <= 1'b1;
                        r_mul_go    <= 1'b1;
                        r_state     <= S_TERM_DIV;
                    end
                end
                S_TERM_DIV: begin
                    if (mul_done) begin
                        r_term_mag <= mul_res;
                        r_i        <= r_i + IW'(1);
                        r_state    <= S_SER_ADD;
                    end
                end
                S_SER_END: begin
                    if (!r_odd) begin
                        if (r_action == ACT_COS) begin
                            r_result <= clamp_out(near_zero ? 64'sd0 : r_sum);
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else if (near_zero) begin
                            r_result.value  <= '0;
                            r_result.status <= ST_NEAR;
                            r_done          <= 1'b1;
                            r_state         <= S_IDLE;
                        end else begin
                            r_c_mag    <= sum_mag;
                            r_tan_neg  <= r_sum[63];
                            r_odd      <= 1'b1;
                            r_i        <= '0;
                            r_sum      <= '0;
                            r_term_mag <= r_x_mag;
                            r_term_neg <= r_x_neg;
                            r_state    <= S_SER_ADD;
                        end
                    end else if (r_action == ACT_SIN) begin
                        r_result <= clamp_out(r_sum);
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_tan_neg  <= r_tan_neg ^ r_sum[63];
                        r_div_num  <= 128'(sum_mag) << RESULT_FRAC_BITS;
                        r_div_den  <= r_c_mag;
                        r_div_go   <= 1'b1;
                        r_state    <= S_TAN_DIV;
                    end
                end
                S_TAN_DIV: begin
                    if (div_done) begin
                        r_result <= clamp_out(tan_val);
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    tsd_mul #(
        .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_mul_go),
        .i_rad   (r_mul_rad),
        .i_recip (r_mul_recip),
        .i_rsh   (r_mul_rsh),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    tsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_div_go),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    `TSD_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result shown while busy")
    `TSD_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "item not taken")
    `TSD_ASSERT_SAME(a_status_code, i_clk, i_rst_n, o_done,
        o_result.status == ST_OK || o_result.status == ST_NEAR || o_result.status == ST_SAT,
        "bad status code")
    `TSD_ASSERT_SAME(a_near_zero_val, i_clk, i_rst_n, o_done && o_result.status == ST_NEAR,
        o_result.value == '0, "near zero tangent with nonzero value")

endmodule

`default_nettype wire
